// ----- sv/s1pnc_pkg.sv -----
// Shared types, constants and round helpers for the SHA-1 nonce checker.
package s1pnc_pkg;

  localparam int unsigned MaxNonceLength = 15;
  localparam int unsigned PrefixLen      = 40;
  localparam int unsigned NumRounds      = 80;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 64;

  localparam logic [CfgIdxW-1:0] CfgPrefix0  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPrefix1  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPrefix2  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPrefix3  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPrefix4  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTarget01 = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgTarget23 = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgTarget4  = 3'd7;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } hstate_t;

  // sideband carried along the pipe
  typedef struct packed {
    logic len_err;
  } side_t;

  function automatic word_t rotl(input word_t v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  function automatic hstate_t round_step(input hstate_t s, input word_t w,
                                         input int unsigned r);
    word_t f;
    word_t k;
    hstate_t o;
    if (r < 20) begin
      f = (s.b & s.c) | (~s.b & s.d); k = K0;
    end else if (r < 40) begin
      f = s.b ^ s.c ^ s.d; k = K1;
    end else if (r < 60) begin
      f = (s.b & s.c) | (s.b & s.d) | (s.c & s.d); k = K2;
    end else begin
      f = s.b ^ s.c ^ s.d; k = K3;
    end
    o.a = rotl(s.a, 5) + f + s.e + w + k;
    o.b = s.a;
    o.c = rotl(s.b, 30);
    o.d = s.c;
    o.e = s.d;
    round_step = o;
  endfunction

endpackage

// ----- sv/s1pnc_pad.sv -----
// Message block builder: prefix, nonce bytes, padding and bit length.
module s1pnc_pad import s1pnc_pkg::*; #(
  parameter int unsigned MaxLen = MaxNonceLength
) (
  input  logic [319:0]   prefix_i,
  input  logic [63:0]    first_i,
  input  logic [55:0]    rest_i,
  input  logic [3:0]     len_i,
  output logic [511:0]   block_o
);
  logic [3:0]  len_sat;
  logic [119:0] nonce;
  logic [191:0] tail;
  logic [15:0] bits;

  always_comb begin
    len_sat = (len_i > 4'(MaxLen)) ? 4'(MaxLen) : len_i;
    nonce   = {first_i, rest_i};
    tail    = '0;
    for (int i = 0; i < 15; i++) begin
      if (i < int'(len_sat)) begin
        tail[191-8*i -: 8] = nonce[119-8*i -: 8];
      end
    end
    // end marker lands right after the last nonce byte, up to byte 55
    for (int i = 0; i < 16; i++) begin
      if (i == int'(len_sat)) begin
        tail[191-8*i -: 8] = 8'h80;
      end
    end
    bits = 16'((PrefixLen + 32'(len_sat)) * 8);
    tail[15:0] = bits;
    block_o = {prefix_i, tail};
  end
endmodule

// ----- sv/s1pnc_stage.sv -----
// One SHA-1 round stage: a round plus schedule window advance, registered.
module s1pnc_stage import s1pnc_pkg::*; #(
  parameter int unsigned Round = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  side_t     side_i,
  input  hstate_t   st_i,
  input  logic [511:0] win_i,
  output logic      valid_o,
  output side_t     side_o,
  output hstate_t   st_o,
  output logic [511:0] win_o
);
  // window holds w[r..r+15], w[r] in the top word
  word_t   wnew;
  hstate_t st_d;

  always_comb begin
    wnew = rotl(win_i[511-32*13 -: 32] ^ win_i[511-32*8 -: 32] ^
                win_i[511-32*2 -: 32] ^ win_i[511 -: 32], 1);
    st_d = round_step(st_i, win_i[511 -: 32], Round);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      st_o   <= st_d;
      win_o  <= {win_i[479:0], wnew};
    end
  end
endmodule

// ----- sv/sha1_prefix_nonce_checker.sv -----
// SHA-1 prefix plus nonce checker: 80-stage round pipeline with compare stage.
// Hashes a 40-byte configured prefix followed by a 1..15 byte nonce as one
// padded SHA-1 block and compares the digest with a configured target. One
// word is accepted every cycle while the pipe is not stalled; each result is
// taken by the input register at the accepting edge, then by one register
// per SHA-1 round and one for the final add and compare before it is offered.
// A stall while a result is held on the output freezes the whole pipe and stalls the input with it.
module sha1_prefix_nonce_checker import s1pnc_pkg::*; #(
  parameter int unsigned MaxLen = MaxNonceLength
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [63:0]         nonce_first_bytes_i,
  input  logic [55:0]         nonce_rest_bytes_i,
  input  logic [3:0]          nonce_length_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                match_o,
  output logic                length_error_o,
  output logic [31:0]         digest_word_0_o,
  output logic [31:0]         digest_word_1_o,
  output logic [31:0]         digest_word_2_o,
  output logic [31:0]         digest_word_3_o,
  output logic [31:0]         digest_word_4_o
);
  logic [63:0] prefix_q [5];
  logic [63:0] tgt01_q, tgt23_q;
  logic [31:0] tgt4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) prefix_q[i] <= '0;
      tgt01_q <= '0;
      tgt23_q <= '0;
      tgt4_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPrefix0:  prefix_q[0] <= cfg_data_i;
        CfgPrefix1:  prefix_q[1] <= cfg_data_i;
        CfgPrefix2:  prefix_q[2] <= cfg_data_i;
        CfgPrefix3:  prefix_q[3] <= cfg_data_i;
        CfgPrefix4:  prefix_q[4] <= cfg_data_i;
        CfgTarget01: tgt01_q     <= cfg_data_i;
        CfgTarget23: tgt23_q     <= cfg_data_i;
        CfgTarget4:  tgt4_q      <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // whole pipe advances unless a held result is stalled
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic [511:0] block;
  s1pnc_pad #(.MaxLen(MaxLen)) u_pad (
    .prefix_i ({prefix_q[0], prefix_q[1], prefix_q[2], prefix_q[3], prefix_q[4]}),
    .first_i  (nonce_first_bytes_i),
    .rest_i   (nonce_rest_bytes_i),
    .len_i    (nonce_length_i),
    .block_o  (block)
  );

  logic         v_q   [NumRounds+1];
  side_t        sd_q  [NumRounds+1];
  hstate_t      st_q  [NumRounds+1];
  logic [511:0] win_q [NumRounds+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0].len_err <= (nonce_length_i == 4'd0);
      st_q[0]  <= '{a: H0, b: H1, c: H2, d: H3, e: H4};
      win_q[0] <= block;
    end
  end

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    s1pnc_stage #(.Round(r)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_q[r]),
      .side_i  (sd_q[r]),
      .st_i    (st_q[r]),
      .win_i   (win_q[r]),
      .valid_o (v_q[r+1]),
      .side_o  (sd_q[r+1]),
      .st_o    (st_q[r+1]),
      .win_o   (win_q[r+1])
    );
  end

  hstate_t fin;
  logic    eq;
  logic    err;
  always_comb begin
    err   = sd_q[NumRounds].len_err;
    fin.a = st_q[NumRounds].a + H0;
    fin.b = st_q[NumRounds].b + H1;
    fin.c = st_q[NumRounds].c + H2;
    fin.d = st_q[NumRounds].d + H3;
    fin.e = st_q[NumRounds].e + H4;
    eq = (fin.a == tgt01_q[63:32]) && (fin.b == tgt01_q[31:0]) &&
         (fin.c == tgt23_q[63:32]) && (fin.d == tgt23_q[31:0]) && (fin.e == tgt4_q);
    if (err) fin = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= v_q[NumRounds];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      match_o         <= eq && !err;
      length_error_o  <= err;
      digest_word_0_o <= fin.a;
      digest_word_1_o <= fin.b;
      digest_word_2_o <= fin.c;
      digest_word_3_o <= fin.d;
      digest_word_4_o <= fin.e;
    end
  end
endmodule
